/* design/ber_tlv_tag_finder_core_macros.svh */
// assertion macros for the ber-tlv tag finder
// used by ber_tlv_tag_finder_core.sv; expects aclk and aresetn in scope
`ifndef BER_TLV_TAG_FINDER_CORE_MACROS_SVH
`define BER_TLV_TAG_FINDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define BTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property checked on every edge, reset included
`define BTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define BTF_ASSERT(lbl, prop, msg)
`define BTF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* design/btf_pkg.sv */
// shared types and constants for the ber-tlv tag finder
// no dependencies
package btf_pkg;

    localparam int OFFSET_W = 15;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    typedef enum logic [1:0] {
        KIND_VALUE     = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_ERROR     = 2'd3
    } btf_kind_t;

    typedef struct packed {
        logic                valid;
        btf_kind_t           kind;
        logic [7:0]          value_byte;
        logic [15:0]         value_length;
        logic [OFFSET_W-1:0] end_offset;
        logic                last_of_match;
    } btf_result_t;

endpackage

/* design/ber_tlv_tag_finder_core.sv */
// top level of the ber-tlv tag finder: input register, parser, result register
// depends on btf_pkg, btf_parser and ber_tlv_tag_finder_core_macros.svh
//
// usage:
//   s_ channel: one buffer byte per transaction, s_last_byte flags the final byte
//   m_ channel: result transactions (value bytes of the first object whose tag
//     equals target_tag, an empty-match marker, not found, or malformed)
//   cfg channel: writes target_tag; always ready, write it only while idle
//   an accepted byte is held in the input register; its result, if any, is
//     registered in the result register once that register is free
//   throughput: one byte per cycle while m_ready keeps up; the parser state
//     update is combinational logic from the input to the result register
//   at most one result per byte; bytes after an outcome up to the flagged
//   last byte produce nothing
//   reset (aresetn low, synchronous) clears target_tag, the parser and the
//   valid flags of both pipeline registers
//   when the receiver stalls, the result register holds and the input
//   register still takes one more byte; s_ready falls once both are full
`include "ber_tlv_tag_finder_core_macros.svh"

module ber_tlv_tag_finder_core import btf_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 2
) (
    input  logic                aclk,
    input  logic                aresetn,

    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,

    // byte input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_last_byte,

    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [7:0]          m_value_byte,
    output logic [15:0]         m_value_length,
    output logic [OFFSET_W-1:0] m_end_offset,
    output logic                m_last_of_match
);

    logic [15:0] target_tag_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register
    logic        out_valid_reg;
    btf_result_t out_reg;

    btf_result_t step_res;
    logic        advance;
    logic        step_en;

    // result register free or emptied this cycle
    assign advance   = !out_valid_reg || m_ready;
    assign step_en   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_tag_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            target_tag_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= step_res.valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance && step_res.valid) begin
            out_reg <= step_res;
        end
    end

    btf_parser #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .target_tag (target_tag_reg),
        .step_en    (step_en),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .res        (step_res)
    );

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_value_byte    = out_reg.value_byte;
    assign m_value_length  = out_reg.value_length;
    assign m_end_offset    = out_reg.end_offset;
    assign m_last_of_match = out_reg.last_of_match;

    // no result right after reset
    `BTF_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_valid,
        "result valid right after reset")

    // a fresh result needs a byte in the input register
    `BTF_ASSERT(a_result_from_byte, m_valid && !$past(m_valid) |-> $past(in_valid_reg),
        "result appeared with no byte in flight")

    // non-value results close the outcome and carry no byte
    `BTF_ASSERT(a_outcome_closes,
        m_valid && m_kind != KIND_VALUE |-> m_last_of_match && m_value_byte == 8'h00,
        "outcome result without last_of_match or with a value byte")

    // empty input register never back-pressures
    `BTF_ASSERT(a_ready_when_empty, !in_valid_reg |-> s_ready,
        "input stalled with empty input register")

endmodule

/* design/btf_parser.sv */
// per-byte tlv parser: walks tag, length and value fields and builds the result
// depends on btf_pkg
module btf_parser import btf_pkg::*; #(
    parameter int MAX_LENGTH_BYTES = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] target_tag,
    input  logic        step_en,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output btf_result_t res
);

    localparam int LEN_CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [2:0] {
        PH_TAG1,
        PH_TAG2,
        PH_LEN1,
        PH_LENX,
        PH_SKIP,
        PH_MATCH
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [7:0]            first_tag_reg, first_tag_next;
    logic [15:0]           cur_tag_reg, cur_tag_next;
    logic [LEN_CNT_W-1:0]  len_left_reg, len_left_next;
    logic [15:0]           obj_len_reg, obj_len_next;
    logic [15:0]           val_left_reg, val_left_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;
    logic                  done_reg, done_next;

    logic [OFFSET_W-1:0]   offset_inc;
    logic [15:0]           val_left_dec;
    logic [OFFSET_W+1:0]   end_sum;
    logic [6:0]            len_cnt;
    logic                  hdr;

    always_comb begin
        phase_next     = phase_reg;
        first_tag_next = first_tag_reg;
        cur_tag_next   = cur_tag_reg;
        len_left_next  = len_left_reg;
        obj_len_next   = obj_len_reg;
        val_left_next  = val_left_reg;
        offset_next    = offset_reg;
        done_next      = done_reg;
        res            = '0;
        hdr            = 1'b0;

        offset_inc   = (offset_reg != OFFSET_MAX) ? offset_reg + 1'b1 : offset_reg;
        val_left_dec = val_left_reg - 16'd1;
        end_sum      = {2'b00, offset_inc} + {1'b0, val_left_dec};
        len_cnt      = data_byte[6:0];

        if (step_en && !done_reg) begin
            offset_next = offset_inc;
            case (phase_reg)
                PH_TAG1: begin
                    if (data_byte == 8'h00) begin
                        // padding byte, only counted
                    end else if (data_byte[4:0] == 5'h1F) begin
                        first_tag_next = data_byte;
                        phase_next     = PH_TAG2;
                    end else begin
                        cur_tag_next = {8'h00, data_byte};
                        phase_next   = PH_LEN1;
                    end
                end
                PH_TAG2: begin
                    cur_tag_next = {first_tag_reg, data_byte};
                    phase_next   = PH_LEN1;
                end
                PH_LEN1: begin
                    if (data_byte[7]) begin
                        if (len_cnt == 7'd0 || len_cnt > 7'(MAX_LENGTH_BYTES)) begin
                            // indefinite or oversized long form
                            res.valid         = 1'b1;
                            res.kind          = KIND_ERROR;
                            res.last_of_match = 1'b1;
                            res.end_offset    = offset_inc;
                            done_next         = 1'b1;
                        end else begin
                            len_left_next = len_cnt[LEN_CNT_W-1:0];
                            obj_len_next  = '0;
                            phase_next    = PH_LENX;
                        end
                    end else begin
                        obj_len_next = {8'h00, data_byte};
                        hdr          = 1'b1;
                    end
                end
                PH_LENX: begin
                    obj_len_next  = {obj_len_reg[7:0], data_byte};
                    len_left_next = len_left_reg - 1'b1;
                    if (len_left_reg == LEN_CNT_W'(1)) begin
                        hdr = 1'b1;
                    end
                end
                PH_SKIP: begin
                    val_left_next = val_left_dec;
                    if (val_left_dec == 16'd0) begin
                        phase_next = PH_TAG1;
                    end
                end
                PH_MATCH: begin
                    val_left_next      = val_left_dec;
                    res.valid          = 1'b1;
                    res.kind           = KIND_VALUE;
                    res.value_byte     = data_byte;
                    res.value_length   = obj_len_reg;
                    res.end_offset     = (end_sum > {2'b00, OFFSET_MAX}) ? OFFSET_MAX
                                                                         : end_sum[OFFSET_W-1:0];
                    if (val_left_dec == 16'd0) begin
                        res.last_of_match = 1'b1;
                        done_next         = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_TAG1;
                end
            endcase

            if (hdr) begin
                if (cur_tag_reg == target_tag) begin
                    if (obj_len_next == 16'd0) begin
                        res.valid         = 1'b1;
                        res.kind          = KIND_EMPTY;
                        res.last_of_match = 1'b1;
                        res.value_length  = '0;
                        res.end_offset    = offset_inc;
                        done_next         = 1'b1;
                    end else begin
                        val_left_next = obj_len_next;
                        phase_next    = PH_MATCH;
                    end
                end else if (obj_len_next == 16'd0) begin
                    phase_next = PH_TAG1;
                end else begin
                    val_left_next = obj_len_next;
                    phase_next    = PH_SKIP;
                end
            end

            // buffer ends with no outcome yet
            if (last_byte && !done_next) begin
                res.valid         = 1'b1;
                res.kind          = (phase_next == PH_TAG1) ? KIND_NOT_FOUND : KIND_ERROR;
                res.value_byte    = '0;
                res.value_length  = (phase_next == PH_MATCH) ? obj_len_next : '0;
                res.end_offset    = offset_inc;
                res.last_of_match = 1'b1;
            end
        end

        if (step_en && last_byte) begin
            phase_next     = PH_TAG1;
            first_tag_next = '0;
            cur_tag_next   = '0;
            len_left_next  = '0;
            obj_len_next   = '0;
            val_left_next  = '0;
            offset_next    = '0;
            done_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TAG1;
            first_tag_reg <= '0;
            cur_tag_reg   <= '0;
            len_left_reg  <= '0;
            obj_len_reg   <= '0;
            val_left_reg  <= '0;
            offset_reg    <= '0;
            done_reg      <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            first_tag_reg <= first_tag_next;
            cur_tag_reg   <= cur_tag_next;
            len_left_reg  <= len_left_next;
            obj_len_reg   <= obj_len_next;
            val_left_reg  <= val_left_next;
            offset_reg    <= offset_next;
            done_reg      <= done_next;
        end
    end

endmodule
